// ===== rtl/core/cstf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cstf_pkg: shared types and constants of the comment stripping text filter
// Request and result item layouts, scan mode codes and character constants.
// ----------------------------------------------------------------------------
package cstf_pkg;

   localparam logic [7:0] CHAR_HASH      = 8'h23;  // '#'
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;  // '\n'
   localparam logic [7:0] CHAR_TAB       = 8'h09;  // '\t'
   localparam logic [7:0] CHAR_SPACE     = 8'h20;  // ' '
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;  // '"'
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;  // '\'
   localparam logic [7:0] CHAR_GREATER   = 8'h3E;  // '>'
   localparam logic [7:0] CHAR_LESS      = 8'h3C;  // '<'

   typedef enum logic [2:0] {
      MODE_PLAIN = 3'd0,
      MODE_STR   = 3'd1,
      MODE_ESC   = 3'd2,
      MODE_LINE  = 3'd3,
      MODE_CMT   = 3'd4
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_text;
   } req_data_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_in_run;
      logic       text_done;
   } rsp_data_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_NEWLINE);
   endfunction

endpackage

// ===== rtl/core/comment_stripping_text_filter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_stripping_text_filter_unit: hash comment stripper
// Copies text bytes out with '#' comments removed; strings and '> ' / '< '
// line spans pass verbatim. Each request yields zero, one or two results.
// ----------------------------------------------------------------------------
// A result is registered and appears in the cycle after its request is accepted.
// Requests are taken one per cycle while each yields at most one result and
//   the output is not stalled; a request that yields two results holds the
//   next one off while the two-entry result register drains its first result.
// Reset: synchronous, active high; plain mode, nothing held, at text start,
//   result register empty.
module comment_stripping_text_filter_unit
   import cstf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data
);

   // Scan state
   scan_mode_type mode_ff, mode_in;
   logic [7:0]    held_char_ff, held_char_in;
   logic          held_valid_ff, held_valid_in;
   logic          boundary_ff, boundary_in;

   // Result register: two slots, a fill count and a head pointer
   rsp_data_type  slot_ff [2];
   rsp_data_type  slot_in [2];
   logic [1:0]    cnt_ff, cnt_in;
   logic          head_ff, head_in;

   logic          req_accept, rsp_accept;
   logic [1:0]    n_res;
   logic [7:0]    c;
   logic          bnd_eff;
   logic          skip;

   assign rsp_valid  = (cnt_ff != 2'd0);
   assign rsp_data   = slot_ff[head_ff];
   assign rsp_accept = rsp_valid && !rsp_stall;

   // Take a new request only when the result register is empty after this cycle
   assign req_stall  = !((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_accept));
   assign req_accept = req_valid && !req_stall;

   // Per-byte step: results and next scan state
   always_comb begin
      c             = req_data.in_char;
      mode_in       = mode_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      boundary_in   = boundary_ff;
      n_res         = 2'd0;
      slot_in[0]    = '0;
      slot_in[1]    = '0;
      bnd_eff       = boundary_ff;
      skip          = 1'b0;

      if (req_data.end_of_text) begin
         // Flush the held byte, then close the text with a newline
         if (held_valid_ff) begin
            slot_in[0].out_char  = held_char_ff;
            slot_in[1].out_char  = CHAR_NEWLINE;
            slot_in[1].text_done = 1'b1;
            n_res                = 2'd2;
         end else begin
            slot_in[0].out_char  = CHAR_NEWLINE;
            slot_in[0].text_done = 1'b1;
            n_res                = 2'd1;
         end
         mode_in       = MODE_PLAIN;
         held_char_in  = '0;
         held_valid_in = 1'b0;
         boundary_in   = 1'b1;
      end else begin
         unique case (mode_ff)
            MODE_STR: begin
               slot_in[0].out_char = c;
               n_res               = 2'd1;
               if (c == CHAR_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end else if (c == CHAR_QUOTE) begin
                  mode_in     = MODE_PLAIN;
                  boundary_in = 1'b1;
               end
            end
            MODE_ESC: begin
               slot_in[0].out_char = c;
               n_res               = 2'd1;
               mode_in             = MODE_STR;
            end
            MODE_LINE: begin
               slot_in[0].out_char = c;
               n_res               = 2'd1;
               if (c == CHAR_NEWLINE) begin
                  mode_in     = MODE_PLAIN;
                  boundary_in = 1'b1;
               end
            end
            MODE_CMT: begin
               // Drop comment bytes; the newline stands in for the comment
               if (c == CHAR_NEWLINE) begin
                  slot_in[0].out_char = CHAR_NEWLINE;
                  n_res               = 2'd1;
                  mode_in             = MODE_PLAIN;
                  boundary_in         = 1'b1;
               end
            end
            default: begin
               mode_in = MODE_PLAIN;
               if (held_valid_ff) begin
                  held_valid_in = 1'b0;
                  held_char_in  = '0;
                  if (is_blank(held_char_ff) && (c == CHAR_HASH)) begin
                     // Whitespace before '#': drop both, open a comment
                     mode_in     = MODE_CMT;
                     boundary_in = 1'b0;
                     skip        = 1'b1;
                  end else begin
                     slot_in[0].out_char = held_char_ff;
                     n_res               = 2'd1;
                     if (((held_char_ff == CHAR_GREATER) || (held_char_ff == CHAR_LESS))
                         && (c == CHAR_SPACE)) begin
                        slot_in[1].out_char = c;
                        n_res               = 2'd2;
                        mode_in             = MODE_LINE;
                        boundary_in         = 1'b0;
                        skip                = 1'b1;
                     end else begin
                        bnd_eff = 1'b0;
                     end
                  end
               end
               if (!skip) begin
                  if ((c == CHAR_HASH) && bnd_eff) begin
                     mode_in     = MODE_CMT;
                     boundary_in = 1'b0;
                  end else begin
                     boundary_in = 1'b0;
                     if (is_blank(c) || (c == CHAR_GREATER) || (c == CHAR_LESS)) begin
                        // Hold for one byte of lookahead
                        held_char_in  = c;
                        held_valid_in = 1'b1;
                     end else begin
                        if (c == CHAR_QUOTE) begin
                           mode_in = MODE_STR;
                        end
                        if (n_res == 2'd0) begin
                           slot_in[0].out_char = c;
                        end else begin
                           slot_in[1].out_char = c;
                        end
                        n_res = n_res + 2'd1;
                     end
                  end
               end
            end
         endcase
      end

      // Mark the last result of this request
      if (n_res == 2'd1) begin
         slot_in[0].last_in_run = 1'b1;
      end else if (n_res == 2'd2) begin
         slot_in[1].last_in_run = 1'b1;
      end
   end

   // Result register bookkeeping
   always_comb begin
      cnt_in  = cnt_ff;
      head_in = head_ff;
      if (rsp_accept) begin
         if (cnt_ff == 2'd2) begin
            cnt_in  = 2'd1;
            head_in = 1'b1;
         end else begin
            cnt_in  = 2'd0;
            head_in = 1'b0;
         end
      end
      if (req_accept) begin
         cnt_in  = n_res;
         head_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_PLAIN;
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
         boundary_ff   <= 1'b1;
         cnt_ff        <= 2'd0;
         head_ff       <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         head_ff <= head_in;
         if (req_accept) begin
            mode_ff       <= mode_in;
            held_char_ff  <= held_char_in;
            held_valid_ff <= held_valid_in;
            boundary_ff   <= boundary_in;
         end
      end
   end

   // Payload slots: load on accept only
   always_ff @(posedge clock) begin
      if (req_accept) begin
         slot_ff[0] <= slot_in[0];
         slot_ff[1] <= slot_in[1];
      end
   end

   // Fill count never exceeds the two slots
   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("result register overfilled");

   // A request only lands on a result register that is empty or being emptied
   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_accept))
      else $error("request accepted over pending results");

   // The second slot is at the head only as the last remaining result
   assert property (@(posedge clock) disable iff (reset) head_ff |-> (cnt_ff == 2'd1))
      else $error("head pointer out of step with fill count");

   // End of text returns the scanner to its start state
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.end_of_text) |=>
         (mode_ff == MODE_PLAIN) && !held_valid_ff && boundary_ff)
      else $error("scanner not reset after end of text");

   // The closing newline is always the last result of its request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.text_done) |-> rsp_data.last_in_run)
      else $error("closing newline not last in run");

endmodule
